// File: src/mfd_pkg.sv
`timescale 1ns / 1ps
package mfd_pkg;

	localparam int unsigned NUM_LEVELS = 3;
	localparam logic [1:0] LAST_LEVEL = 2'(NUM_LEVELS - 1);
	localparam logic [23:0] MAX24 = 24'hFFFFFF;

	localparam logic [15:0] QUANT0_RST = 16'd5;
	localparam logic [15:0] QUANT1_RST = 16'd10;
	localparam logic [15:0] QUANT2_RST = 16'd9999;

	typedef enum logic [1:0] {
		OP_LOAD     = 2'd0,
		OP_DISPATCH = 2'd1,
		OP_CLEAR    = 2'd2,
		OP_NONE     = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		CFG_QUANT0 = 2'd0,
		CFG_QUANT1 = 2'd1,
		CFG_QUANT2 = 2'd2,
		CFG_NONE   = 2'd3
	} cfg_idx_t;

	localparam logic [1:0] ST_RAN  = 2'd0;
	localparam logic [1:0] ST_IDLE = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	typedef struct packed {
		logic [15:0] arrival;
		logic [15:0] remaining;
		logic [1:0]  level;
		logic [23:0] wait_acc;
	} entry_t;

	typedef struct packed {
		logic   valid;
		logic   eligible;
		entry_t entry;
	} sample_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [4:0]  chosen_slot;
		logic [15:0] slice_length;
		logic [23:0] slice_start;
		logic        first_dispatch;
		logic        task_done;
		logic [23:0] finish_time;
		logic [23:0] turnaround;
		logic [23:0] wait_total;
		logic [1:0]  level_after;
	} result_t;

	function automatic logic [23:0] sat_add24(input logic [23:0] a, input logic [15:0] b);
		logic [24:0] s;
		s = {1'b0, a} + {9'd0, b};
		return s[24] ? MAX24 : s[23:0];
	endfunction

endpackage

// File: src/mfd_select.sv
`timescale 1ns / 1ps
module mfd_select #(
	parameter int IW = 5
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               clr,
	input  mfd_pkg::sample_t   smp,
	input  logic [IW-1:0]      smp_idx,
	output logic               found,
	output logic [IW-1:0]      best_idx,
	output mfd_pkg::entry_t    best
);
	import mfd_pkg::*;

	logic better;

	// entries arrive in index order, so a strict compare keeps the lowest index
	assign better = smp.valid && smp.eligible && (!found ||
		smp.entry.level < best.level ||
		(smp.entry.level == best.level && smp.entry.arrival < best.arrival));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found <= 1'b0;
		end else if (clr) begin
			found <= 1'b0;
		end else if (better) begin
			found <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (better) begin
			best_idx <= smp_idx;
			best     <= smp.entry;
		end
	end

endmodule

// File: src/multilevel_feedback_dispatcher.sv
`timescale 1ns / 1ps
// Three-level feedback dispatcher over a table of MAX_TASKS tasks.
// Input stream s_*: s_tuser carries the operation (load, dispatch, clear);
// s_tdata carries the slot, arrival time and burst length of a load.
// Loads and clears give no result. A dispatch gives one
// result item on m_*: m_tuser is the status, m_tdata the slice fields.
// Task records sit in a one-port-read, one-port-write memory with a
// registered read. A dispatch sweeps the memory once to pick the task,
// then a second time to add the slice to every other waiting task, then
// writes the chosen entry back. An idle tick or an empty table needs only
// the first sweep.
// The result goes to an output register; s_tready returns as soon as that
// register takes it, so the next item is accepted while the result waits.
// If the receiver stalls, a finished dispatch holds until the register frees.
// Reset (and a clear item) empties the table and zeroes the clock; reset
// also restores the quanta to 5, 10 and 9999. No clearing pass is needed:
// per-entry valid flags sit in flip-flops.
// cfg_we writes quantum register cfg_addr at any edge; do so only when idle.
module multilevel_feedback_dispatcher #(
	parameter int MAX_TASKS = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [39:0]  s_tdata,   // task_slot[4:0], arrival_time[20:5], burst_length[36:21]
	input  logic [1:0]   s_tuser,   // operation[1:0]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,   // chosen_slot[4:0], slice_length[20:5], slice_start[44:21],
	                                // first_dispatch[45], task_done[46], finish_time[70:47],
	                                // turnaround[94:71], wait_total[118:95], level_after[120:119]
	output logic [1:0]   m_tuser,   // status[1:0]
	input  logic         cfg_we,
	input  logic [1:0]   cfg_addr,
	input  logic [15:0]  cfg_wdata
);
	import mfd_pkg::*;

	localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam logic [IW:0]   CNT_END = (IW + 1)'(MAX_TASKS);
	localparam logic [IW-1:0] LAST_IDX = IW'(MAX_TASKS - 1);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_SCAN = 6'b000010,
		S_CALC = 6'b000100,
		S_WAIT = 6'b001000,
		S_FIN  = 6'b010000,
		S_OUT  = 6'b100000
	} state_t;

	state_t              state_q;
	logic [IW:0]         cnt_q;
	logic                rvld_s1;
	logic [IW-1:0]       ridx_s1;
	entry_t              rdata_s1;
	entry_t              mem [MAX_TASKS];
	logic [MAX_TASKS-1:0] valid_q, fin_q, started_q;
	logic [23:0]         clk_now_q;
	logic [15:0]         quant0_q, quant1_q, quant2_q;
	logic [15:0]         run_q;
	result_t             res_q;
	logic                m_tvalid_q;
	result_t             m_res_q;

	logic                accept, issue, elig_s1, last_s1, pending;
	logic [IW-1:0]       raddr, slot_idx;
	logic                we;
	logic [IW-1:0]       waddr;
	entry_t              wdata;
	op_t                 op;
	logic [4:0]          in_slot;
	logic [15:0]         in_arr, in_burst;
	sample_t             smp;
	logic                found;
	logic [IW-1:0]       best_idx;
	entry_t              best;
	logic [15:0]         q_raw, q_eff, rem_new;
	logic [23:0]         finish, wait_sum;
	logic [24:0]         wsum;
	logic [1:0]          lvl_next;

	assign op       = op_t'(s_tuser);
	assign in_slot  = s_tdata[4:0];
	assign in_arr   = s_tdata[20:5];
	assign in_burst = s_tdata[36:21];
	assign slot_idx = IW'(in_slot);

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign issue    = (state_q == S_SCAN || state_q == S_WAIT) && (cnt_q < CNT_END);
	assign raddr    = cnt_q[IW-1:0];
	assign last_s1  = rvld_s1 && (ridx_s1 == LAST_IDX);
	assign pending  = |(valid_q & ~fin_q);
	assign elig_s1  = valid_q[ridx_s1] && !fin_q[ridx_s1] &&
		({8'd0, rdata_s1.arrival} <= clk_now_q);

	assign smp.valid    = rvld_s1 && (state_q == S_SCAN);
	assign smp.eligible = elig_s1;
	assign smp.entry    = rdata_s1;

	mfd_select #(.IW(IW)) u_select (
		.clk      (clk),
		.arst_n   (arst_n),
		.clr      (accept),
		.smp      (smp),
		.smp_idx  (ridx_s1),
		.found    (found),
		.best_idx (best_idx),
		.best     (best)
	);

	always_comb begin
		case (best.level)
			2'd0:    q_raw = quant0_q;
			2'd1:    q_raw = quant1_q;
			default: q_raw = quant2_q;
		endcase
		q_eff    = (q_raw == 16'd0) ? 16'd1 : q_raw;
		rem_new  = best.remaining - run_q;
		finish   = sat_add24(clk_now_q, run_q);
		wsum     = {1'b0, rdata_s1.wait_acc} + {9'd0, run_q};
		wait_sum = wsum[24] ? MAX24 : wsum[23:0];
		lvl_next = (rem_new == 16'd0 || best.level >= LAST_LEVEL) ? best.level
			: best.level + 2'd1;
	end

	// memory write port: load, wait sweep, chosen write-back
	always_comb begin
		we    = 1'b0;
		waddr = ridx_s1;
		wdata = rdata_s1;
		if (accept && op == OP_LOAD && {27'd0, in_slot} < 32'(MAX_TASKS)) begin
			we    = 1'b1;
			waddr = slot_idx;
			wdata = '{arrival: in_arr, remaining: in_burst, level: 2'd0, wait_acc: 24'd0};
		end else if (state_q == S_WAIT && rvld_s1 && elig_s1 && ridx_s1 != best_idx) begin
			we             = 1'b1;
			wdata.wait_acc = wait_sum;
		end else if (state_q == S_FIN) begin
			we              = 1'b1;
			waddr           = best_idx;
			wdata           = best;
			wdata.remaining = rem_new;
			wdata.level     = lvl_next;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_s1 <= mem[raddr];
		ridx_s1  <= raddr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quant0_q <= QUANT0_RST;
			quant1_q <= QUANT1_RST;
			quant2_q <= QUANT2_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_addr))
				CFG_QUANT0: quant0_q <= cfg_wdata;
				CFG_QUANT1: quant1_q <= cfg_wdata;
				CFG_QUANT2: quant2_q <= cfg_wdata;
				default:    ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			rvld_s1    <= 1'b0;
			valid_q    <= '0;
			fin_q      <= '0;
			started_q  <= '0;
			clk_now_q  <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			rvld_s1 <= issue;
			if (issue) begin
				cnt_q <= cnt_q + (IW + 1)'(1);
			end
			if (m_tvalid_q && m_tready && state_q != S_OUT) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (accept) begin
						case (op)
							OP_LOAD: begin
								if ({27'd0, in_slot} < 32'(MAX_TASKS)) begin
									valid_q[slot_idx]   <= 1'b1;
									fin_q[slot_idx]     <= (in_burst == 16'd0);
									started_q[slot_idx] <= 1'b0;
								end
							end
							OP_DISPATCH: state_q <= S_SCAN;
							OP_CLEAR: begin
								valid_q   <= '0;
								fin_q     <= '0;
								started_q <= '0;
								clk_now_q <= '0;
							end
							default: ;
						endcase
					end
				end
				S_SCAN: begin
					if (last_s1) begin
						state_q <= S_CALC;
					end
				end
				S_CALC: begin
					cnt_q <= '0;
					if (!pending) begin
						res_q   <= '{status: ST_DONE, slice_start: clk_now_q,
							finish_time: clk_now_q, default: '0};
						state_q <= S_OUT;
					end else if (!found) begin
						clk_now_q <= sat_add24(clk_now_q, 16'd1);
						res_q     <= '{status: ST_IDLE, slice_length: 16'd1,
							slice_start: clk_now_q, finish_time: sat_add24(clk_now_q, 16'd1),
							default: '0};
						state_q   <= S_OUT;
					end else begin
						res_q.slice_start <= clk_now_q;
						run_q   <= (best.remaining < q_eff) ? best.remaining : q_eff;
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (last_s1) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					started_q[best_idx] <= 1'b1;
					if (rem_new == 16'd0) begin
						fin_q[best_idx] <= 1'b1;
					end
					clk_now_q            <= finish;
					res_q.status         <= ST_RAN;
					res_q.chosen_slot    <= 5'(best_idx);
					res_q.slice_length   <= run_q;
					res_q.first_dispatch <= !started_q[best_idx];
					res_q.task_done      <= (rem_new == 16'd0);
					res_q.finish_time    <= finish;
					res_q.turnaround     <= (rem_new == 16'd0) ? finish - {8'd0, best.arrival}
						: 24'd0;
					res_q.wait_total     <= best.wait_acc;
					res_q.level_after    <= lvl_next;
					state_q              <= S_OUT;
				end
				S_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && (!m_tvalid_q || m_tready)) begin
			m_res_q <= res_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_res_q.status;
	assign m_tdata  = {7'd0, m_res_q.level_after, m_res_q.wait_total, m_res_q.turnaround,
		m_res_q.finish_time, m_res_q.task_done, m_res_q.first_dispatch,
		m_res_q.slice_start, m_res_q.slice_length, m_res_q.chosen_slot};

	a_clear_zeroes_clock: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && op == OP_CLEAR) |=> (clk_now_q == 24'd0 && valid_q == '0))
		else $error("clear did not empty the table");

	a_idle_tick_len: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == ST_IDLE) |-> (m_tdata[20:5] == 16'd1))
		else $error("idle tick with wrong slice length");

	a_fin_has_choice: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN) |-> (found && valid_q[best_idx] && !fin_q[best_idx]))
		else $error("write-back without a chosen task");

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
module tb;
	import mfd_pkg::*;

	localparam int SLOTS = 32;
	localparam int CYCLE_LIMIT = 600000;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [39:0]  s_tdata;   // task_slot, arrival_time, burst_length
	logic [1:0]   s_tuser;   // operation
	logic         m_tvalid;
	logic         m_tready;
	logic [127:0] m_tdata;   // chosen_slot .. level_after
	logic [1:0]   m_tuser;   // status
	logic         cfg_we;
	logic [1:0]   cfg_addr;
	logic [15:0]  cfg_wdata;

	multilevel_feedback_dispatcher uut (.*);

	// predictor state
	logic [15:0] quanta [3];
	bit          t_valid [SLOTS];
	bit          t_fin   [SLOTS];
	bit          t_start [SLOTS];
	logic [15:0] t_arr   [SLOTS];
	logic [15:0] t_rem   [SLOTS];
	logic [1:0]  t_lvl   [SLOTS];
	logic [23:0] t_wait  [SLOTS];
	logic [23:0] sched_clock;

	result_t pending_slices [$];
	int      mismatches;
	int      cycles;
	bit      idle_enable;

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic logic [23:0] add_sat(logic [23:0] a, logic [15:0] b);
		logic [24:0] s;
		s = {1'b0, a} + {9'd0, b};
		return s[24] ? 24'hFFFFFF : s[23:0];
	endfunction

	task automatic wipe_table();
		for (int i = 0; i < SLOTS; i++) begin
			t_valid[i] = 0; t_fin[i] = 0; t_start[i] = 0;
			t_arr[i] = 0; t_rem[i] = 0; t_lvl[i] = 0; t_wait[i] = 0;
		end
		sched_clock = 0;
	endtask

	function automatic result_t predict_dispatch();
		result_t r;
		int pick;
		bit any_left;
		logic [23:0] t0;
		logic [1:0] lv;
		logic [15:0] q, run;
		r = '0;
		pick = -1;
		any_left = 0;
		t0 = sched_clock;
		for (int i = 0; i < SLOTS; i++) begin
			if (!t_valid[i] || t_fin[i]) continue;
			any_left = 1;
			if (24'(t_arr[i]) > t0) continue;
			if (pick < 0 || t_lvl[i] < t_lvl[pick] ||
			    (t_lvl[i] == t_lvl[pick] && t_arr[i] < t_arr[pick]))
				pick = i;
		end
		r.slice_start = t0;
		if (!any_left) begin
			r.status = ST_DONE;
			r.finish_time = t0;
			return r;
		end
		if (pick < 0) begin
			sched_clock = add_sat(sched_clock, 16'd1);
			r.status = ST_IDLE;
			r.slice_length = 16'd1;
			r.finish_time = sched_clock;
			return r;
		end
		lv = t_lvl[pick] > LAST_LEVEL ? LAST_LEVEL : t_lvl[pick];
		q = quanta[lv] == 0 ? 16'd1 : quanta[lv];
		run = t_rem[pick] < q ? t_rem[pick] : q;
		for (int i = 0; i < SLOTS; i++)
			if (i != pick && t_valid[i] && !t_fin[i] && 24'(t_arr[i]) <= t0)
				t_wait[i] = add_sat(t_wait[i], run);
		r.status = ST_RAN;
		r.first_dispatch = !t_start[pick];
		t_start[pick] = 1;
		t_rem[pick] = t_rem[pick] - run;
		sched_clock = add_sat(sched_clock, run);
		r.chosen_slot = 5'(pick);
		r.slice_length = run;
		r.finish_time = sched_clock;
		r.wait_total = t_wait[pick];
		if (t_rem[pick] == 0) begin
			t_fin[pick] = 1;
			r.task_done = 1;
			r.turnaround = sched_clock - 24'(t_arr[pick]);
		end else if (lv < LAST_LEVEL) begin
			lv++;
		end
		t_lvl[pick] = lv;
		r.level_after = lv;
		return r;
	endfunction

	task automatic report(string what, logic [23:0] got, logic [23:0] want);
		$display("slice mismatch on %s: got %0d, want %0d", what, got, want);
		mismatches++;
	endtask

	// check each result item
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			result_t w;
			if (pending_slices.size() == 0) begin
				report("unexpected item, status", 24'(m_tuser), 24'd0);
			end else begin
				w = pending_slices.pop_front();
				if (m_tuser != w.status) report("status", 24'(m_tuser), 24'(w.status));
				if (m_tdata[4:0] != w.chosen_slot)
					report("chosen_slot", 24'(m_tdata[4:0]), 24'(w.chosen_slot));
				if (m_tdata[20:5] != w.slice_length)
					report("slice_length", 24'(m_tdata[20:5]), 24'(w.slice_length));
				if (m_tdata[44:21] != w.slice_start)
					report("slice_start", m_tdata[44:21], w.slice_start);
				if (m_tdata[45] != w.first_dispatch)
					report("first_dispatch", 24'(m_tdata[45]), 24'(w.first_dispatch));
				if (m_tdata[46] != w.task_done)
					report("task_done", 24'(m_tdata[46]), 24'(w.task_done));
				if (m_tdata[70:47] != w.finish_time)
					report("finish_time", m_tdata[70:47], w.finish_time);
				if (m_tdata[94:71] != w.turnaround)
					report("turnaround", m_tdata[94:71], w.turnaround);
				if (m_tdata[118:95] != w.wait_total)
					report("wait_total", m_tdata[118:95], w.wait_total);
				if (m_tdata[120:119] != w.level_after)
					report("level_after", 24'(m_tdata[120:119]), 24'(w.level_after));
			end
		end
	end

	// receiver stalls in short bursts
	initial begin
		m_tready = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (idle_enable && $urandom_range(0, 5) == 0) begin
				m_tready <= 0;
				repeat ($urandom_range(1, 3) - 1) @(posedge clk);
			end else begin
				m_tready <= 1;
			end
		end
	end

	// leave s_tvalid high after the accepting edge; the next item or drain() settles it
	task automatic send_item(op_t op, logic [4:0] slot = '0, logic [15:0] arr = '0,
	                         logic [15:0] burst = '0);
		if (idle_enable && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= op;
		s_tdata <= {3'b0, burst, arr, slot};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		case (op)
			OP_LOAD: begin
				t_valid[slot] = 1;
				t_fin[slot] = (burst == 0);
				t_start[slot] = 0;
				t_arr[slot] = arr;
				t_rem[slot] = burst;
				t_lvl[slot] = 0;
				t_wait[slot] = 0;
			end
			OP_DISPATCH: pending_slices.push_back(predict_dispatch());
			OP_CLEAR: wipe_table();
			default: ;
		endcase
	endtask

	task automatic drain();
		s_tvalid <= 0;
		while (pending_slices.size() != 0) @(posedge clk);
		repeat (2 * SLOTS + 20) @(posedge clk);
	endtask

	task automatic write_quantum(cfg_idx_t idx, logic [15:0] val);
		drain();
		cfg_we <= 1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 0;
		if (idx != CFG_NONE) quanta[idx] = val;
	endtask

	task automatic test_directed();
		send_item(OP_DISPATCH);                      // nothing left
		send_item(OP_LOAD, 5'd31, 16'd3, 16'hFFFF);
		send_item(OP_LOAD, 5'd0, 16'd0, 16'd0);      // zero burst
		send_item(OP_LOAD, 5'd7, 16'd0, 16'd7);
		send_item(OP_LOAD, 5'd8, 16'hFFFF, 16'd1);
		send_item(OP_NONE, 5'd3, 16'd1, 16'd1);      // ignored
		repeat (8) send_item(OP_DISPATCH);
		send_item(OP_CLEAR);
		send_item(OP_LOAD, 5'd2, 16'd2, 16'd1);
		repeat (4) send_item(OP_DISPATCH);           // idle ticks then run
	endtask

	task automatic test_quanta();
		write_quantum(CFG_QUANT0, 16'd0);            // acts as one
		write_quantum(CFG_QUANT1, 16'hFFFF);
		write_quantum(CFG_QUANT2, 16'd1);
		write_quantum(CFG_NONE, 16'd77);
		send_item(OP_CLEAR);
		send_item(OP_LOAD, 5'd4, 16'd0, 16'hFFFF);
		send_item(OP_LOAD, 5'd5, 16'd0, 16'h8000);
		repeat (6) send_item(OP_DISPATCH);
		write_quantum(CFG_QUANT2, 16'hFFFF);
		// long bursts drive the clock and waits high, though short of saturation
		for (int i = 0; i < 30; i++) begin
			send_item(OP_LOAD, 5'(i), 16'd0, 16'hFFFF);
			repeat (3) send_item(OP_DISPATCH);
		end
		repeat (300) send_item(OP_DISPATCH);
	endtask

	task automatic test_random(int n);
		int op_sel;
		for (int i = 0; i < n; i++) begin
			if (i == n - 150) idle_enable = 0;
			op_sel = $urandom_range(0, 99);
			if (op_sel < 40)
				send_item(OP_LOAD, 5'($urandom), 16'($urandom_range(0, 200)),
				          $urandom_range(0, 9) == 0 ? 16'($urandom) : 16'($urandom_range(0, 40)));
			else if (op_sel < 43)
				send_item(OP_LOAD, 5'($urandom), 16'($urandom), 16'($urandom));
			else if (op_sel < 95)
				send_item(OP_DISPATCH);
			else if (op_sel < 98)
				send_item(OP_CLEAR);
			else
				send_item(OP_NONE, 5'($urandom), 16'($urandom), 16'($urandom));
		end
	endtask

	initial begin
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		s_tuser = OP_LOAD;
		cfg_we = 0;
		cfg_addr = CFG_QUANT0;
		cfg_wdata = '0;
		mismatches = 0;
		cycles = 0;
		idle_enable = 1;
		quanta[0] = 16'd5; quanta[1] = 16'd10; quanta[2] = 16'd9999;
		wipe_table();
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_quanta();
		send_item(OP_CLEAR);
		write_quantum(CFG_QUANT0, 16'd3);
		write_quantum(CFG_QUANT1, 16'd8);
		write_quantum(CFG_QUANT2, 16'd20);
		test_random(250);
		idle_enable = 1;
		write_quantum(CFG_QUANT0, 16'd1);
		write_quantum(CFG_QUANT1, 16'd2);
		write_quantum(CFG_QUANT2, 16'd5);
		test_random(250);
		idle_enable = 1;
		write_quantum(CFG_QUANT0, 16'd5);
		write_quantum(CFG_QUANT1, 16'd10);
		write_quantum(CFG_QUANT2, 16'd9999);
		test_random(200);
		drain();
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
